// File: src/ptt_pkg.sv
// Shared types and codes of the pending transaction timeout table.
`default_nettype none

package ptt_pkg;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_TAKE   = 2'd1,
        OP_DELETE = 2'd2,
        OP_TICK   = 2'd3
    } ptt_op_t;

    typedef enum logic [2:0] {
        KIND_ADDED       = 3'd0,
        KIND_FULL        = 3'd1,
        KIND_TAKEN       = 3'd2,
        KIND_TAKE_MISS   = 3'd3,
        KIND_DELETED     = 3'd4,
        KIND_DELETE_MISS = 3'd5,
        KIND_EXPIRED     = 3'd6,
        KIND_TICK_DONE   = 3'd7
    } ptt_kind_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ADD,
        S_FIND,
        S_TICK
    } ptt_state_t;

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] end_to_end_id;
        logic [31:0] hop_by_hop_id;
        logic [31:0] context_handle;
        logic        has_callback;
        logic        release_flag;
        logic [15:0] timeout_seconds;
        logic [31:0] now_time;
    } ptt_item_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] out_end_to_end_id;
        logic [31:0] out_hop_by_hop_id;
        logic [31:0] out_context;
        logic        out_notify;
        logic        out_release_flag;
        logic [31:0] out_expiry;
        logic        last;
    } ptt_result_t;

    typedef struct packed {
        logic [31:0] e2e;
        logic [31:0] hbh;
        logic [31:0] ctx;
        logic        notify;
        logic        drop;
        logic [31:0] expiry;
    } ptt_entry_t;

    // Classified work word handed from the front to the back.
    typedef struct packed {
        ptt_op_t     op;
        ptt_entry_t  entry;
        logic [31:0] now_time;
    } ptt_job_t;

endpackage

`default_nettype wire

// File: src/ptt_if.sv
// Handshake channels of the table: request items in, result words out.
`default_nettype none

interface ptt_in_if;
    logic              valid;
    logic              ready;
    ptt_pkg::ptt_item_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ptt_out_if;
    logic                valid;
    logic                ready;
    ptt_pkg::ptt_result_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: src/ptt_front.sv
// Front end: accepts requests, computes expiry, queues classified jobs.
`default_nettype none

module ptt_front (
    input  wire logic        clk,
    input  wire logic        rst_n,
    ptt_in_if.sink           in_ch,
    output ptt_pkg::ptt_job_t job,
    output logic             job_valid,
    input  wire logic        job_ready
);
    import ptt_pkg::*;

    ptt_job_t    queue_reg [QUEUE_DEPTH];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  fill_reg, fill_next;
    logic        push, pop;
    logic [32:0] sum;
    ptt_job_t    incoming;

    assign in_ch.ready = (fill_reg != 2'(QUEUE_DEPTH));
    assign push        = in_ch.valid && in_ch.ready;
    assign job_valid   = (fill_reg != 2'd0);
    assign pop         = job_valid && job_ready;
    assign job         = queue_reg[rd_ptr_reg];

    always_comb
    begin
        sum = {1'b0, in_ch.data.now_time} + {17'd0, in_ch.data.timeout_seconds};
        incoming.op           = ptt_op_t'(in_ch.data.command);
        incoming.entry.e2e    = in_ch.data.end_to_end_id;
        incoming.entry.hbh    = in_ch.data.hop_by_hop_id;
        incoming.entry.ctx    = in_ch.data.context_handle;
        incoming.entry.notify = in_ch.data.has_callback;
        incoming.entry.drop   = in_ch.data.release_flag;
        // saturate at the time maximum
        incoming.entry.expiry = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        incoming.now_time     = in_ch.data.now_time;
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= incoming;
        end
    end

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= 2'(QUEUE_DEPTH)) else $error("queue overfilled");
    a_fill_track: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> fill_reg == $past(fill_reg) + 2'd1)
        else $error("queue fill lost a push");
    a_ptr_sync: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg == 2'd0 || fill_reg == 2'(QUEUE_DEPTH)) |-> wr_ptr_reg == rd_ptr_reg)
        else $error("queue pointers out of step");
`endif

endmodule

`default_nettype wire

// File: src/ptt_engine.sv
// Back end: age-ordered entry table, scan sequencer and result register.
`default_nettype none

module ptt_engine #(
    parameter int TABLE_DEPTH = 32
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire ptt_pkg::ptt_job_t job,
    input  wire logic              job_valid,
    output logic                   job_ready,
    ptt_out_if.source              out_ch
);
    import ptt_pkg::*;

    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int AW = $clog2(TABLE_DEPTH);

    // Entries held in age order: position 0 is the oldest.
    ptt_entry_t  table_reg [TABLE_DEPTH];
    ptt_state_t  state_reg, state_next;
    ptt_job_t    job_reg;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic        ovalid_reg, ovalid_next;
    ptt_result_t odata_reg, odata_next;
    logic        can_emit, write_en, remove_en, at_end;
    ptt_entry_t  cur;

    assign can_emit  = !ovalid_reg || out_ch.ready;
    assign cur       = table_reg[idx_reg[AW-1:0]];
    assign at_end    = (idx_reg == count_reg);
    assign out_ch.valid = ovalid_reg;
    assign out_ch.data  = odata_reg;

    function automatic ptt_result_t make_result(ptt_kind_t k, ptt_entry_t e, logic fin);
        ptt_result_t r;
        r.kind              = k;
        r.out_end_to_end_id = e.e2e;
        r.out_hop_by_hop_id = e.hbh;
        r.out_context       = e.ctx;
        r.out_notify        = e.notify;
        r.out_release_flag  = e.drop;
        r.out_expiry        = e.expiry;
        r.last              = fin;
        return r;
    endfunction

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        ovalid_next = ovalid_reg && !out_ch.ready;
        odata_next  = odata_reg;
        job_ready   = 1'b0;
        write_en    = 1'b0;
        remove_en   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                job_ready = 1'b1;
                idx_next  = '0;
                if (job_valid)
                begin
                    unique case (job.op)
                        OP_ADD:             state_next = S_ADD;
                        OP_TAKE, OP_DELETE: state_next = S_FIND;
                        default:            state_next = S_TICK;
                    endcase
                end
            end
            S_ADD:
            begin
                if (can_emit)
                begin
                    ovalid_next = 1'b1;
                    state_next  = S_IDLE;
                    if (count_reg == CW'(TABLE_DEPTH))
                    begin
                        odata_next = make_result(KIND_FULL, '0, 1'b1);
                    end
                    else
                    begin
                        write_en   = 1'b1;
                        count_next = count_reg + CW'(1);
                        odata_next = make_result(KIND_ADDED, job_reg.entry, 1'b1);
                    end
                end
            end
            S_FIND:
            begin
                if (can_emit)
                begin
                    if (at_end)
                    begin
                        ovalid_next = 1'b1;
                        state_next  = S_IDLE;
                        odata_next  = make_result((job_reg.op == OP_TAKE) ?
                            KIND_TAKE_MISS : KIND_DELETE_MISS, '0, 1'b1);
                    end
                    else if (cur.e2e == job_reg.entry.e2e && cur.hbh == job_reg.entry.hbh)
                    begin
                        ovalid_next = 1'b1;
                        state_next  = S_IDLE;
                        remove_en   = 1'b1;
                        count_next  = count_reg - CW'(1);
                        odata_next  = make_result((job_reg.op == OP_TAKE) ?
                            KIND_TAKEN : KIND_DELETED, cur, 1'b1);
                    end
                    else
                    begin
                        idx_next = idx_reg + CW'(1);
                    end
                end
            end
            S_TICK:
            begin
                if (can_emit)
                begin
                    if (at_end)
                    begin
                        ovalid_next = 1'b1;
                        state_next  = S_IDLE;
                        odata_next  = make_result(KIND_TICK_DONE, '0, 1'b1);
                    end
                    else if (job_reg.now_time > cur.expiry)
                    begin
                        // drop and hold the position: the next entry slides in
                        ovalid_next = 1'b1;
                        remove_en   = 1'b1;
                        count_next  = count_reg - CW'(1);
                        odata_next  = make_result(KIND_EXPIRED, cur, 1'b0);
                    end
                    else
                    begin
                        idx_next = idx_reg + CW'(1);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            idx_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            idx_reg    <= idx_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        odata_reg <= odata_next;
        if (job_ready && job_valid)
        begin
            job_reg <= job;
        end
        if (write_en)
        begin
            table_reg[count_reg[AW-1:0]] <= job_reg.entry;
        end
        for (int j = 0; j < TABLE_DEPTH - 1; j++)
        begin
            if (remove_en && CW'(j) >= idx_reg)
            begin
                table_reg[j] <= table_reg[j + 1];
            end
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(TABLE_DEPTH)) else $error("entry count beyond depth");
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= count_reg) else $error("scan index past table fill");
    a_add_grow: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_ADD && can_emit && count_reg != CW'(TABLE_DEPTH)
        |=> count_reg == $past(count_reg) + CW'(1)) else $error("add did not grow table");
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |=> !$rose(ovalid_reg)) else $error("result from idle");
`endif

endmodule

`default_nettype wire

// File: src/pending_transaction_timeout_table_core.sv
// Top level of the pending transaction timeout table.
`default_nettype none

// Holds up to TABLE_DEPTH outstanding transactions in arrival order. An add
// passes the request queue and the job register of the back end, then offers
// its one word from the result register. Take and delete walk the table
// oldest first, one entry per cycle while no result word waits, and give
// one word. A tick walks the table the same way and gives one expired word
// per removed entry plus a final done word. The back end returns to idle to
// pick up the next request. A result word that waits stalls the walk; a
// two-word request queue lets new requests arrive while one is worked on,
// and the result register holds a word until it is taken. No clearing pass
// follows reset.
module pending_transaction_timeout_table_core #(
    parameter int TABLE_DEPTH = 32
) (
    input  wire logic clk,
    input  wire logic rst_n,
    ptt_in_if.sink    in_ch,
    ptt_out_if.source out_ch
);
    import ptt_pkg::*;

    ptt_job_t job;
    logic     job_valid;
    logic     job_ready;

    ptt_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .job       (job),
        .job_valid (job_valid),
        .job_ready (job_ready)
    );

    ptt_engine #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .job       (job),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .out_ch    (out_ch)
    );

endmodule

`default_nettype wire
